@@ hdl/mpsa_pkg.sv @@
// Shared types and constants of the multi-pool slot allocator.
// Used by every module of the block but mpsa_ram; depends on nothing.
package mpsa_pkg;

  localparam int MaxPools = 8;
  localparam int FuncW    = 2;
  localparam int PoolW    = 3;
  localparam int SlotW    = 8;
  localparam int MaskW    = 8;
  localparam int StatW    = 2;
  localparam int UsedW    = 9;

  typedef enum logic [FuncW-1:0] {
    FUNC_BORROW = 2'd0,
    FUNC_RETURN = 2'd1,
    FUNC_GROUP  = 2'd2
  } func_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOT_HELD = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_GROUP
  } state_e;

  typedef struct packed {
    logic [PoolW-1:0] pool;
    logic [SlotW-1:0] slot;
    status_e          status;
    logic [UsedW-1:0] used;
    logic             last;
  } result_t;

  typedef struct packed {
    logic             inc;
    logic             dec;
    logic [PoolW-1:0] pool;
  } ctr_cmd_t;

endpackage

@@ hdl/mpsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module mpsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/mpsa_ctr.sv @@
// Per-pool in-use counters and high-water marks of the slot allocator.
// Depends on mpsa_pkg for the counter command struct.
module mpsa_ctr #(
  parameter int NP    = 8,
  parameter int SLOTS = 256,
  localparam int CW   = $clog2(SLOTS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpsa_pkg::ctr_cmd_t   cmd_i,
  output logic [CW-1:0]        cnt_o [NP],
  output logic [NP-1:0]        full_o,
  output logic [NP-1:0]        hit_o
);

  logic [CW-1:0] cnt_q [NP];
  logic [CW-1:0] cnt_d [NP];
  logic [CW-1:0] hw_q  [NP];
  logic [CW-1:0] hw_d  [NP];

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      cnt_d[i] = cnt_q[i];
      hw_d[i]  = hw_q[i];
      if (cmd_i.pool == mpsa_pkg::PoolW'(i)) begin
        if (cmd_i.inc) begin
          cnt_d[i] = cnt_q[i] + 1'b1;
          // first pop past the mark: entry was never written, raise the mark
          if (cnt_q[i] == hw_q[i]) begin
            hw_d[i] = hw_q[i] + 1'b1;
          end
        end else if (cmd_i.dec) begin
          cnt_d[i] = cnt_q[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        cnt_q[i] <= '0;
        hw_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NP; i++) begin
        cnt_q[i] <= cnt_d[i];
        hw_q[i]  <= hw_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      cnt_o[i]  = cnt_q[i];
      full_o[i] = (cnt_q[i] == CW'(SLOTS));
      hit_o[i]  = (cnt_q[i] < hw_q[i]);
    end
  end

  for (genvar g = 0; g < NP; g++) begin : g_chk
    a_cnt_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cnt_q[g] <= hw_q[g]) && (hw_q[g] <= CW'(SLOTS)))
      else $error("pool count above high-water mark or slot count");
  end

  a_inc_dec_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.inc && cmd_i.dec))
    else $error("counter pushed and popped in one cycle");

endmodule

@@ hdl/mpsa_out.sv @@
// Two-entry result buffer: a result stage and the output register.
// Depends on mpsa_pkg for the result struct.
module mpsa_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mpsa_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mpsa_pkg::result_t out_o
);

  logic              res_valid_q, res_valid_d;
  logic              out_valid_q, out_valid_d;
  mpsa_pkg::result_t res_q;
  mpsa_pkg::result_t out_q;
  logic              move;

  always_comb begin
    move        = res_valid_q && (!out_valid_q || !out_stall_i);
    free_o      = !res_valid_q || move;
    res_valid_d = load_i || (res_valid_q && !move);
    out_valid_d = move || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
    if (move) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result loaded over a waiting result");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("waiting result not moved into empty output register");

endmodule

@@ hdl/multi_pool_slot_allocator.sv @@
// Multi-pool slot allocator: LIFO free lists of slots, one list per pool.
// Depends on mpsa_pkg, mpsa_ram, mpsa_ctr and mpsa_out.
//
// Requests come in on in_valid_i/in_stall_o (func, pool, slot, pool_mask);
// results leave on out_valid_o/out_stall_i, one or more per answered request,
// the final one flagged by last_o. A request is taken when valid is high and
// stall is low on the same rising edge.
// A return, and a borrow answered with an error, is answered from the idle
// state. A borrow first reads the free-stack RAM, then returns its data.
// A group borrow first checks all named pools, then issues one RAM read per
// granted slot, or reports each empty pool in turn.
// A new request is taken only in the idle state.
// A mask naming no pool, or an unknown func, yields no result.
// Reset clears all in-use counts at once; no clearing pass is needed, since
// entries at or above each pool's high-water mark read back as their own index.
// When the receiver stalls, one result sits in the output register and one
// in the result stage; the next request is taken as long as the result
// stage can drain or is empty.
module multi_pool_slot_allocator #(
  parameter int POOLS = 8,
  parameter int SLOTS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mpsa_pkg::FuncW-1:0]    func_i,
  input  logic [mpsa_pkg::PoolW-1:0]    pool_i,
  input  logic [mpsa_pkg::SlotW-1:0]    slot_i,
  input  logic [mpsa_pkg::MaskW-1:0]    pool_mask_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mpsa_pkg::PoolW-1:0]    result_pool_o,
  output logic [mpsa_pkg::SlotW-1:0]    granted_slot_o,
  output logic [mpsa_pkg::StatW-1:0]    status_o,
  output logic [mpsa_pkg::UsedW-1:0]    slots_in_use_o,
  output logic                          last_o
);

  // only pools reachable by the 3-bit pool field get storage
  localparam int NP    = (POOLS < mpsa_pkg::MaxPools) ? POOLS : mpsa_pkg::MaxPools;
  localparam int PIW   = (NP > 1) ? $clog2(NP) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int Depth = NP * SLOTS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int AWX   = AW + 1;

  function automatic logic [mpsa_pkg::UsedW-1:0] used_of(input logic [CW-1:0] c);
    logic [CW+mpsa_pkg::UsedW-1:0] w;
    w = {{mpsa_pkg::UsedW{1'b0}}, c};
    return w[mpsa_pkg::UsedW-1:0];
  endfunction

  function automatic logic [mpsa_pkg::SlotW-1:0] idx_of(input logic [CW-1:0] c);
    logic [CW+mpsa_pkg::SlotW-1:0] w;
    w = {{mpsa_pkg::SlotW{1'b0}}, c};
    return w[mpsa_pkg::SlotW-1:0];
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [PIW-1:0] p,
                                             input logic [CW-1:0] c);
    logic [AW:0] a;
    a = AWX'(p) * AWX'(SLOTS) + AWX'(c);
    return a[AW-1:0];
  endfunction

  mpsa_pkg::state_e   state_q, state_d;
  logic [NP-1:0]      work_q, work_d;
  logic               grp_err_q, grp_err_d;

  logic [mpsa_pkg::PoolW-1:0] rd_pool_q, rd_pool_d;
  logic [mpsa_pkg::UsedW-1:0] rd_used_q, rd_used_d;
  logic [mpsa_pkg::SlotW-1:0] rd_idx_q, rd_idx_d;
  logic                       rd_hit_q, rd_hit_d;
  logic                       rd_last_q, rd_last_d;

  logic [CW-1:0]      cnt [NP];
  logic [NP-1:0]      full;
  logic [NP-1:0]      hit;
  mpsa_pkg::ctr_cmd_t cmd;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [mpsa_pkg::SlotW-1:0] ram_rdata;

  logic              out_free, res_load;
  mpsa_pkg::result_t res, out_res;

  logic              in_accept, pool_ok, any_empty;
  logic [PIW-1:0]    pidx, gp;
  logic [CW-1:0]     cur, gcnt;
  logic [NP-1:0]     masked, lowest, work_rest;
  logic              gp_last;

  mpsa_ram #(
    .Width (mpsa_pkg::SlotW),
    .Depth (Depth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (slot_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mpsa_ctr #(
    .NP    (NP),
    .SLOTS (SLOTS)
  ) u_ctr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .cnt_o  (cnt),
    .full_o (full),
    .hit_o  (hit)
  );

  mpsa_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  always_comb begin
    in_stall_o = !((state_q == mpsa_pkg::S_IDLE) && out_free);
    in_accept  = in_valid_i && !in_stall_o;
    pool_ok    = ({1'b0, pool_i} < 4'(NP));
    pidx       = pool_i[PIW-1:0];
    cur        = cnt[pidx];
    masked     = pool_mask_i[NP-1:0];
    any_empty  = |(masked & full);

    lowest    = work_q & (~work_q + 1'b1);
    work_rest = work_q & ~lowest;
    gp_last   = (work_rest == '0);
    gp        = '0;
    for (int i = NP - 1; i >= 0; i--) begin
      if (work_q[i]) begin
        gp = PIW'(i);
      end
    end
    gcnt = cnt[gp];
  end

  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    grp_err_d = grp_err_q;
    rd_pool_d = rd_pool_q;
    rd_used_d = rd_used_q;
    rd_idx_d  = rd_idx_q;
    rd_hit_d  = rd_hit_q;
    rd_last_d = rd_last_q;
    cmd       = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    res_load  = 1'b0;
    res       = '0;

    unique case (state_q)
      mpsa_pkg::S_IDLE: begin
        if (in_accept) begin
          unique case (mpsa_pkg::func_e'(func_i))
            mpsa_pkg::FUNC_BORROW: begin
              if (!pool_ok) begin
                res_load   = 1'b1;
                res.pool   = pool_i;
                res.status = mpsa_pkg::STAT_EMPTY;
                res.last   = 1'b1;
              end else if (full[pidx]) begin
                res_load   = 1'b1;
                res.pool   = pool_i;
                res.status = mpsa_pkg::STAT_EMPTY;
                res.used   = used_of(cur);
                res.last   = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = addr_of(pidx, cur);
                cmd.inc   = 1'b1;
                cmd.pool  = pool_i;
                rd_pool_d = pool_i;
                rd_used_d = used_of(cur + 1'b1);
                rd_idx_d  = idx_of(cur);
                rd_hit_d  = hit[pidx];
                rd_last_d = 1'b1;
                state_d   = mpsa_pkg::S_READ;
              end
            end
            mpsa_pkg::FUNC_RETURN: begin
              res_load = 1'b1;
              res.pool = pool_i;
              res.last = 1'b1;
              if (!pool_ok || (cur == '0)) begin
                res.status = mpsa_pkg::STAT_NOT_HELD;
              end else begin
                // push: write the slot at the new top and drop the count
                ram_we     = 1'b1;
                ram_waddr  = addr_of(pidx, cur - 1'b1);
                cmd.dec    = 1'b1;
                cmd.pool   = pool_i;
                res.status = mpsa_pkg::STAT_OK;
                res.used   = used_of(cur - 1'b1);
              end
            end
            mpsa_pkg::FUNC_GROUP: begin
              // all-or-nothing: report only the empty pools if any is empty
              work_d    = any_empty ? (masked & full) : masked;
              grp_err_d = any_empty;
              if (masked != '0) begin
                state_d = mpsa_pkg::S_GROUP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      mpsa_pkg::S_READ: begin
        if (out_free) begin
          res_load   = 1'b1;
          res.pool   = rd_pool_q;
          res.slot   = rd_hit_q ? ram_rdata : rd_idx_q;
          res.status = mpsa_pkg::STAT_OK;
          res.used   = rd_used_q;
          res.last   = rd_last_q;
          state_d    = rd_last_q ? mpsa_pkg::S_IDLE : mpsa_pkg::S_GROUP;
        end
      end

      mpsa_pkg::S_GROUP: begin
        if (grp_err_q) begin
          if (out_free) begin
            res_load   = 1'b1;
            res.pool   = mpsa_pkg::PoolW'(gp);
            res.status = mpsa_pkg::STAT_EMPTY;
            res.used   = used_of(gcnt);
            res.last   = gp_last;
            work_d     = work_rest;
            if (gp_last) begin
              state_d = mpsa_pkg::S_IDLE;
            end
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_of(gp, gcnt);
          cmd.inc   = 1'b1;
          cmd.pool  = mpsa_pkg::PoolW'(gp);
          rd_pool_d = mpsa_pkg::PoolW'(gp);
          rd_used_d = used_of(gcnt + 1'b1);
          rd_idx_d  = idx_of(gcnt);
          rd_hit_d  = hit[gp];
          rd_last_d = gp_last;
          work_d    = work_rest;
          state_d   = mpsa_pkg::S_READ;
        end
      end

      default: begin
        state_d = mpsa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mpsa_pkg::S_IDLE;
      work_q    <= '0;
      grp_err_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      work_q    <= work_d;
      grp_err_q <= grp_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pool_q <= rd_pool_d;
    rd_used_q <= rd_used_d;
    rd_idx_q  <= rd_idx_d;
    rd_hit_q  <= rd_hit_d;
    rd_last_q <= rd_last_d;
  end

  assign result_pool_o  = out_res.pool;
  assign granted_slot_o = out_res.slot;
  assign status_o       = out_res.status;
  assign slots_in_use_o = out_res.used;
  assign last_o         = out_res.last;

  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("free-stack RAM read and written in one cycle");

  a_read_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> (state_q == mpsa_pkg::S_READ))
    else $error("RAM read issued without waiting for its data");

endmodule

@@ tb/slot_grant_checker.sv @@
// Checker for the multi-pool slot allocator: watches both request and result
// channels, predicts the grants of every accepted request and compares them.
// Depends on mpsa_pkg.
module slot_grant_checker #(
  parameter int POOLS = 8,
  parameter int SLOTS = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [mpsa_pkg::FuncW-1:0] func_i,
  input  logic [mpsa_pkg::PoolW-1:0] pool_i,
  input  logic [mpsa_pkg::SlotW-1:0] slot_i,
  input  logic [mpsa_pkg::MaskW-1:0] pool_mask_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [mpsa_pkg::PoolW-1:0] result_pool_i,
  input  logic [mpsa_pkg::SlotW-1:0] granted_slot_i,
  input  logic [mpsa_pkg::StatW-1:0] status_i,
  input  logic [mpsa_pkg::UsedW-1:0] slots_in_use_i,
  input  logic                       last_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);

  logic [mpsa_pkg::SlotW-1:0] free_slots [POOLS][SLOTS];
  int unsigned                held [POOLS];
  mpsa_pkg::result_t          expected_grants [$];
  int                         mismatches = 0;
  int                         pending = 0;
  int                         results_seen = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t, result %0d: %s", $time, results_seen, what);
  endtask

  task automatic clear_pools();
    for (int p = 0; p < POOLS; p++) begin
      for (int i = 0; i < SLOTS; i++) begin
        free_slots[p][i] = mpsa_pkg::SlotW'(i);
      end
      held[p] = 0;
    end
    expected_grants.delete();
  endtask

  task automatic push_grant(input int p, input logic [mpsa_pkg::SlotW-1:0] s,
                            input mpsa_pkg::status_e st, input int unsigned used);
    mpsa_pkg::result_t r;
    r.pool   = mpsa_pkg::PoolW'(p);
    r.slot   = s;
    r.status = st;
    r.used   = mpsa_pkg::UsedW'(used);
    r.last   = 1'b0;
    expected_grants.push_back(r);
  endtask

  task automatic predict_grants(input logic [mpsa_pkg::FuncW-1:0] f,
                                input logic [mpsa_pkg::PoolW-1:0] p,
                                input logic [mpsa_pkg::SlotW-1:0] s,
                                input logic [mpsa_pkg::MaskW-1:0] m);
    int   first_new;
    logic any_full;
    first_new = expected_grants.size();
    any_full  = 1'b0;
    case (f)
      mpsa_pkg::FUNC_BORROW: begin
        if (p >= POOLS) begin
          push_grant(p, '0, mpsa_pkg::STAT_EMPTY, 0);
        end else if (held[p] >= SLOTS) begin
          push_grant(p, '0, mpsa_pkg::STAT_EMPTY, held[p]);
        end else begin
          held[p]++;
          push_grant(p, free_slots[p][held[p]-1], mpsa_pkg::STAT_OK, held[p]);
        end
      end
      mpsa_pkg::FUNC_RETURN: begin
        if (p >= POOLS) begin
          push_grant(p, '0, mpsa_pkg::STAT_NOT_HELD, 0);
        end else if (held[p] == 0) begin
          push_grant(p, '0, mpsa_pkg::STAT_NOT_HELD, 0);
        end else begin
          // push the slot back unchecked; it is the next one granted
          held[p]--;
          free_slots[p][held[p]] = s;
          push_grant(p, '0, mpsa_pkg::STAT_OK, held[p]);
        end
      end
      mpsa_pkg::FUNC_GROUP: begin
        for (int q = 0; q < mpsa_pkg::MaxPools && q < POOLS; q++) begin
          if (m[q] && held[q] >= SLOTS) any_full = 1'b1;
        end
        // all or nothing: on any full pool, report only the full ones
        for (int q = 0; q < mpsa_pkg::MaxPools && q < POOLS; q++) begin
          if (m[q]) begin
            if (!any_full) begin
              held[q]++;
              push_grant(q, free_slots[q][held[q]-1], mpsa_pkg::STAT_OK, held[q]);
            end else if (held[q] >= SLOTS) begin
              push_grant(q, '0, mpsa_pkg::STAT_EMPTY, held[q]);
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (expected_grants.size() > first_new) begin
      expected_grants[expected_grants.size()-1].last = 1'b1;
    end
  endtask

  task automatic compare_result();
    mpsa_pkg::result_t want;
    if (expected_grants.size() == 0) begin
      report_mismatch($sformatf("unexpected result pool %0d slot %0d status %0d used %0d",
                                result_pool_i, granted_slot_i, status_i, slots_in_use_i));
    end else begin
      want = expected_grants.pop_front();
      if (result_pool_i !== want.pool)
        report_mismatch($sformatf("pool %0d, expected %0d", result_pool_i, want.pool));
      if (granted_slot_i !== want.slot)
        report_mismatch($sformatf("slot %0d, expected %0d", granted_slot_i, want.slot));
      if (status_i !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
      if (slots_in_use_i !== want.used)
        report_mismatch($sformatf("in use %0d, expected %0d", slots_in_use_i, want.used));
      if (last_i !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last_i, want.last));
    end
    results_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_pools();
    end else begin
      if (in_valid_i && !in_stall_i) predict_grants(func_i, pool_i, slot_i, pool_mask_i);
      if (out_valid_i && !out_stall_i) compare_result();
    end
    pending = expected_grants.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top of the multi-pool slot allocator: clock, reset, request and
// stall stimulus, and the verdict. Depends on mpsa_pkg, slot_grant_checker
// and multi_pool_slot_allocator.
module tb;

  localparam int POOLS          = 8;
  localparam int SLOTS          = 256;
  localparam int RandRequests   = 375;
  localparam int PhaseRequests  = 125;
  localparam int ClimbRequests  = 300;
  localparam int HoldOffCycles  = 300;
  localparam int DrainCycles    = 40;
  localparam logic [mpsa_pkg::FuncW-1:0] FuncUnknown = 2'd3;
  localparam logic [mpsa_pkg::MaskW-1:0] NoPools     = '0;
  localparam logic [mpsa_pkg::MaskW-1:0] AllPools    = '1;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [mpsa_pkg::FuncW-1:0] func = '0;
  logic [mpsa_pkg::PoolW-1:0] pool = '0;
  logic [mpsa_pkg::SlotW-1:0] slot = '0;
  logic [mpsa_pkg::MaskW-1:0] pool_mask = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [mpsa_pkg::PoolW-1:0] result_pool;
  logic [mpsa_pkg::SlotW-1:0] granted_slot;
  logic [mpsa_pkg::StatW-1:0] status;
  logic [mpsa_pkg::UsedW-1:0] slots_in_use;
  logic                       last;
  int                         mismatches;
  int                         pending;

  int send_idle_pct  = 35;
  int recv_stall_pct = 81;
  bit hold_off_req   = 1'b0;

  multi_pool_slot_allocator #(
    .POOLS(POOLS),
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .pool_i        (pool),
    .slot_i        (slot),
    .pool_mask_i   (pool_mask),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_pool_o (result_pool),
    .granted_slot_o(granted_slot),
    .status_o      (status),
    .slots_in_use_o(slots_in_use),
    .last_o        (last)
  );

  slot_grant_checker #(
    .POOLS(POOLS),
    .SLOTS(SLOTS)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .func_i          (func),
    .pool_i          (pool),
    .slot_i          (slot),
    .pool_mask_i     (pool_mask),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .result_pool_i   (result_pool),
    .granted_slot_i  (granted_slot),
    .status_i        (status),
    .slots_in_use_i  (slots_in_use),
    .last_i          (last),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request at a falling edge and hold it until accepted.
  task automatic send_request(input logic [mpsa_pkg::FuncW-1:0] f,
                              input logic [mpsa_pkg::PoolW-1:0] p,
                              input logic [mpsa_pkg::SlotW-1:0] s,
                              input logic [mpsa_pkg::MaskW-1:0] m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid  = 1'b0;
      func      = mpsa_pkg::FuncW'($urandom);
      pool      = mpsa_pkg::PoolW'($urandom);
      slot      = mpsa_pkg::SlotW'($urandom);
      pool_mask = mpsa_pkg::MaskW'($urandom);
      @(negedge clk);
    end
    in_valid  = 1'b1;
    func      = f;
    pool      = p;
    slot      = s;
    pool_mask = m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // hold off long enough for the block to back up into its input
        out_stall = 1'b1;
        for (int n = 0; n < HoldOffCycles; n++) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin : stimulus
    int sent;
    int pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // returns to empty pools find nothing borrowed
    send_request(mpsa_pkg::FUNC_RETURN, 3'd0, 8'h12, NoPools);
    send_request(mpsa_pkg::FUNC_RETURN, 3'd7, 8'hFF, NoPools);
    // fresh pools grant slots in index order
    send_request(mpsa_pkg::FUNC_BORROW, 3'd0, '0, NoPools);
    send_request(mpsa_pkg::FUNC_BORROW, 3'd0, '1, AllPools);
    send_request(mpsa_pkg::FUNC_BORROW, 3'd7, '0, NoPools);
    // a returned slot goes unchecked and is granted next
    send_request(mpsa_pkg::FUNC_RETURN, 3'd0, 8'hAB, NoPools);
    send_request(mpsa_pkg::FUNC_BORROW, 3'd0, '0, NoPools);
    send_request(mpsa_pkg::FUNC_RETURN, 3'd7, 8'h00, NoPools);
    send_request(mpsa_pkg::FUNC_RETURN, 3'd7, 8'hFF, NoPools);
    // no result: group over no pool, unknown func
    send_request(mpsa_pkg::FUNC_GROUP, 3'd5, 8'h5A, NoPools);
    send_request(FuncUnknown, 3'd2, 8'hA5, AllPools);
    send_request(mpsa_pkg::FUNC_GROUP, '0, '0, 8'h01);
    send_request(mpsa_pkg::FUNC_GROUP, '1, '1, 8'h80);
    send_request(mpsa_pkg::FUNC_GROUP, '0, '0, 8'h55);
    send_request(mpsa_pkg::FUNC_GROUP, '0, '0, 8'hAA);
    send_request(mpsa_pkg::FUNC_GROUP, '0, '0, AllPools);
    send_request(mpsa_pkg::FUNC_BORROW, 3'd3, 8'h33, NoPools);
    send_request(mpsa_pkg::FUNC_RETURN, 3'd3, 8'hFF, NoPools);
    send_request(mpsa_pkg::FUNC_RETURN, 3'd5, 8'h01, NoPools);
    send_request(mpsa_pkg::FUNC_GROUP, 3'd4, 8'h80, 8'h81);

    // climb every pool to full with group borrows, then churn around full
    sent = 0;
    while (sent < RandRequests) begin
      if (sent == PhaseRequests) begin
        send_idle_pct  = 81;
        recv_stall_pct = 35;
      end else if (sent == 2 * PhaseRequests) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 1'b1;
      end
      if ($urandom_range(0, 99) < 4) begin
        if ($urandom_range(0, 1) == 0)
          send_request(FuncUnknown, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), mpsa_pkg::MaskW'($urandom));
        else
          send_request(mpsa_pkg::FUNC_GROUP, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), NoPools);
      end
      pick = $urandom_range(0, 99);
      if (sent < ClimbRequests) begin
        if (pick < 85)
          send_request(mpsa_pkg::FUNC_GROUP, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), AllPools);
        else if (pick < 90)
          send_request(mpsa_pkg::FUNC_GROUP, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), mpsa_pkg::MaskW'($urandom_range(1, 255)));
        else if (pick < 97)
          send_request(mpsa_pkg::FUNC_BORROW, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), mpsa_pkg::MaskW'($urandom));
        else
          send_request(mpsa_pkg::FUNC_RETURN, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), mpsa_pkg::MaskW'($urandom));
      end else begin
        if (pick < 30)
          send_request(mpsa_pkg::FUNC_RETURN, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), mpsa_pkg::MaskW'($urandom));
        else if (pick < 55)
          send_request(mpsa_pkg::FUNC_BORROW, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), mpsa_pkg::MaskW'($urandom));
        else if (pick < 75)
          send_request(mpsa_pkg::FUNC_GROUP, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), AllPools);
        else
          send_request(mpsa_pkg::FUNC_GROUP, mpsa_pkg::PoolW'($urandom),
                       mpsa_pkg::SlotW'($urandom), mpsa_pkg::MaskW'($urandom_range(1, 255)));
      end
      sent++;
    end
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
